/* hdl/floor_texture_row_caster_defines.svh */
// assertion macros of the floor texture row caster, used by ftrc_ctrl
// expects clk and arst_n in the scope that uses them
`ifndef FLOOR_TEXTURE_ROW_CASTER_DEFINES_SVH
`define FLOOR_TEXTURE_ROW_CASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FTRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftrc same-cycle check failed");
// next-cycle implication
`define FTRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftrc next-cycle check failed");
`else
`define FTRC_ASSERT_NOW(label, ante, cons)
`define FTRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/ftrc_pkg.sv */
// shared constants, types and helpers of the floor texture row caster
// no dependencies
`timescale 1ns / 1ps

package ftrc_pkg;

	// screen and fixed point geometry
	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int TEXTURE_SIZE  = 64;
	localparam int FRACTION_BITS = 16;
	localparam int HALF_H        = SCREEN_HEIGHT / 2;

	// field widths
	localparam int ROW_W = 9;
	localparam int COL_W = 10;
	localparam int TEX_W = 6;
	localparam int POS_W = 24;
	localparam int DIR_W = 18;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;
	localparam int ACC_W = 32;

	// derived arithmetic widths
	localparam longint HNUM   = longint'(SCREEN_HEIGHT) << FRACTION_BITS;
	localparam int     DIST_W = $clog2(HNUM / 2 + 1);
	localparam int     PROD_W = DIST_W + DIR_W + 1;
	localparam int     OFF_W  = DIST_W + DIR_W + 2;
	localparam int     NUM_W  = PROD_W;
	localparam int     DEN_W  = ROW_W + 1;
	localparam int     CNT_W  = $clog2(NUM_W + 1);
	localparam int     TS_W   = $clog2(TEXTURE_SIZE + 1) > TEX_W ?
		$clog2(TEXTURE_SIZE + 1) : TEX_W;

	// step division: 2 * prod / (SCREEN_WIDTH << FRACTION_BITS) = prod / (5 << 22),
	// a right shift then a divide by five through a rounded-up reciprocal
	// (SCREEN_WIDTH = STEP_ODD << (STEP_SHIFT - FRACTION_BITS + 1))
	localparam int     STEP_SHIFT = FRACTION_BITS + 6;
	localparam int     STEP_ODD   = 5;
	localparam int     SQ_W       = PROD_W - STEP_SHIFT;
	localparam int     RECIP_SH   = 23;
	localparam longint RECIP      = ((longint'(1) << RECIP_SH) + STEP_ODD - 1) / STEP_ODD;
	localparam int     RP_W       = 2 * SQ_W;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_DIR_X   = 3'd2,
		REG_DIR_Y   = 3'd3,
		REG_PLANE_X = 3'd4,
		REG_PLANE_Y = 3'd5
	} reg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;
		logic div_start;
		logic load_dist;
		logic load_prod;
		logic axis_y;
		logic load_world;
		logic load_step;
		logic emit;
		logic from_latch;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic col_zero;
		logic col_ok;
		logic row_ok;
		logic out_free;
		logic div_done;
	} status_t;

	// texel index from the fraction bits of an accumulator
	function automatic logic [TEX_W-1:0] texel_of(input logic [ACC_W-1:0] w);
		logic [FRACTION_BITS+TS_W-1:0] p;
		p = (FRACTION_BITS+TS_W)'(w[FRACTION_BITS-1:0]) *
			(FRACTION_BITS+TS_W)'(TEXTURE_SIZE);
		return p[FRACTION_BITS +: TEX_W];
	endfunction

endpackage

/* hdl/ftrc_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on ftrc_pkg
`timescale 1ns / 1ps

module ftrc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ftrc_pkg::NUM_W-1:0] num,
	input  logic [ftrc_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [ftrc_pkg::NUM_W-1:0] quot
);
	import ftrc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] qt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   rem_nx;
	logic             ge;

	// trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q[DEN_W-1:0], qt_q[NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		rem_nx  = ge ? shifted - {1'b0, den_q} : shifted;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qt_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			qt_q  <= {qt_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = qt_q;

endmodule

/* hdl/ftrc_datapath.sv */
// datapath: configuration registers, row set-up arithmetic, accumulators, result register
// depends on ftrc_pkg and ftrc_div
`timescale 1ns / 1ps

module ftrc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ftrc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ftrc_pkg::CFG_W-1:0] cfg_data,
	input  logic [ftrc_pkg::ROW_W-1:0] row,
	input  logic [ftrc_pkg::COL_W-1:0] column,
	input  ftrc_pkg::cmd_t             cmd,
	output ftrc_pkg::status_t          st,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ftrc_pkg::ROW_W-1:0] floor_row,
	output logic [ftrc_pkg::ROW_W-1:0] ceiling_row,
	output logic [ftrc_pkg::COL_W-1:0] pixel_column,
	output logic [ftrc_pkg::TEX_W-1:0] texel_u,
	output logic [ftrc_pkg::TEX_W-1:0] texel_v
);
	import ftrc_pkg::*;

	logic        [POS_W-1:0]  pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0]  dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic        [ROW_W-1:0]  row_q;
	logic        [COL_W-1:0]  col_q;
	logic        [DIST_W-1:0] dist_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [OFF_W-1:0]  off_q;
	logic        [ACC_W-1:0]  step_mag_q;
	logic        [ACC_W-1:0]  step_x_q, step_y_q, world_x_q, world_y_q;
	logic                     out_valid_q;
	logic        [ROW_W-1:0]  floor_row_q, ceiling_row_q;
	logic        [COL_W-1:0]  pixel_column_q;
	logic        [TEX_W-1:0]  texel_u_q, texel_v_q;

	logic        [ROW_W-1:0]  p;
	logic signed [DIR_W-1:0]  pln, dr;
	logic        [POS_W-1:0]  ps;
	logic signed [DIST_W:0]   dist_s;
	logic signed [DIR_W:0]    diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [OFF_W-1:0]  off;
	logic        [PROD_W-1:0] mag;
	logic        [RP_W-1:0]   step_rp;
	logic signed [OFF_W-1:0]  off_adj;
	logic signed [OFF_W-1:0]  off_sh;
	logic        [ACC_W-1:0]  start_pt;
	logic        [NUM_W-1:0]  quot;
	logic        [ACC_W-1:0]  step_val;
	logic        [NUM_W-1:0]  div_num;
	logic        [DEN_W-1:0]  div_den;
	logic                     div_done;
	logic        [ROW_W-1:0]  src_row;
	logic        [COL_W-1:0]  src_col;

	// decode of the incoming transaction
	always_comb begin
		st.col_zero = column == '0;
		st.col_ok   = int'(column) < SCREEN_WIDTH;
		st.row_ok   = int'(row) > HALF_H && int'(row) < SCREEN_HEIGHT;
		st.out_free = !out_valid_q || !out_stall;
		st.div_done = div_done;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_x_q   <= DIR_W'(65536);
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= DIR_W'(43254);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data[POS_W-1:0];
				REG_POS_Y:   pos_y_q   <= cfg_data[POS_W-1:0];
				REG_DIR_X:   dir_x_q   <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[DIR_W-1:0];
				REG_PLANE_X: plane_x_q <= cfg_data[DIR_W-1:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// per-axis operand selection and products
	always_comb begin
		p      = row_q - ROW_W'(HALF_H);
		pln    = cmd.axis_y ? plane_y_q : plane_x_q;
		dr     = cmd.axis_y ? dir_y_q : dir_x_q;
		ps     = cmd.axis_y ? pos_y_q : pos_x_q;
		dist_s = $signed({1'b0, dist_q});
		diff   = $signed({dr[DIR_W-1], dr}) - $signed({pln[DIR_W-1], pln});
		prod   = dist_s * pln;
		off    = dist_s * diff;
	end

	// start point and step magnitude from the registered products
	always_comb begin
		mag      = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		step_rp  = RP_W'(mag[PROD_W-1:STEP_SHIFT]) * RP_W'(RECIP);
		off_adj  = off_q + (off_q[OFF_W-1] ?
			OFF_W'((longint'(1) << FRACTION_BITS) - 1) : OFF_W'(0));
		off_sh   = off_adj >>> FRACTION_BITS;
		start_pt = ACC_W'(ps) + off_sh[ACC_W-1:0];
		step_val = prod_q[PROD_W-1] ? -step_mag_q : step_mag_q;
		div_num  = NUM_W'(HNUM);
		div_den  = {p, 1'b0};
	end

	ftrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// row set-up registers; the step magnitude is taken with the start point
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			row_q <= row;
			col_q <= column;
		end
		if (cmd.load_dist)
			dist_q <= quot[DIST_W-1:0];
		if (cmd.load_prod) begin
			prod_q <= prod;
			off_q  <= off;
		end
		if (cmd.load_world)
			step_mag_q <= ACC_W'(step_rp[RP_W-1:RECIP_SH]);
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q  <= '0;
			step_y_q  <= '0;
			world_x_q <= '0;
			world_y_q <= '0;
		end else begin
			if (cmd.load_world) begin
				if (cmd.axis_y)
					world_y_q <= start_pt;
				else
					world_x_q <= start_pt;
			end
			if (cmd.load_step) begin
				if (cmd.axis_y)
					step_y_q <= step_val;
				else
					step_x_q <= step_val;
			end
			if (cmd.emit) begin
				world_x_q <= world_x_q + step_x_q;
				world_y_q <= world_y_q + step_y_q;
			end
		end
	end

	// result register
	assign src_row = cmd.from_latch ? row_q : row;
	assign src_col = cmd.from_latch ? col_q : column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			floor_row_q    <= src_row;
			ceiling_row_q  <= ROW_W'(SCREEN_HEIGHT - 1) - src_row;
			pixel_column_q <= src_col;
			texel_u_q      <= texel_of(world_x_q);
			texel_v_q      <= texel_of(world_y_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign floor_row    = floor_row_q;
	assign ceiling_row  = ceiling_row_q;
	assign pixel_column = pixel_column_q;
	assign texel_u      = texel_u_q;
	assign texel_v      = texel_v_q;

endmodule

/* hdl/ftrc_ctrl.sv */
// controller state machine: transaction acceptance and row set-up sequencing
// depends on ftrc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "floor_texture_row_caster_defines.svh"

module ftrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ftrc_pkg::status_t st,
	output ftrc_pkg::cmd_t    cmd
);
	import ftrc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOAD = 10'b0000000010,
		S_DDIS = 10'b0000000100,
		S_MULX = 10'b0000001000,
		S_STX  = 10'b0000010000,
		S_WDX  = 10'b0000100000,
		S_MULY = 10'b0001000000,
		S_STY  = 10'b0010000000,
		S_WDY  = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t state_q, state_nx;
	logic   row_active_q, row_active_nx;
	logic   accept;

	assign in_stall = !(state_q == S_IDLE && st.out_free);
	assign accept   = in_valid && !in_stall;

	// next state and commands
	always_comb begin
		state_nx      = state_q;
		row_active_nx = row_active_q;
		cmd           = '0;
		cmd.axis_y    = state_q == S_MULY || state_q == S_STY || state_q == S_WDY;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = accept;
				if (accept && st.col_ok) begin
					if (st.col_zero) begin
						if (st.row_ok)
							state_nx = S_LOAD;
						else
							row_active_nx = 1'b0;
					end else if (row_active_q && st.row_ok) begin
						cmd.emit = 1'b1;
					end
				end
			end
			S_LOAD: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DDIS;
			end
			S_DDIS: begin
				if (st.div_done) begin
					cmd.load_dist = 1'b1;
					state_nx      = S_MULX;
				end
			end
			S_MULX: begin
				cmd.load_prod = 1'b1;
				state_nx      = S_STX;
			end
			S_STX: begin
				cmd.load_world = 1'b1;
				state_nx       = S_WDX;
			end
			S_WDX: begin
				cmd.load_step = 1'b1;
				state_nx      = S_MULY;
			end
			S_MULY: begin
				cmd.load_prod = 1'b1;
				state_nx      = S_STY;
			end
			S_STY: begin
				cmd.load_world = 1'b1;
				state_nx       = S_WDY;
			end
			S_WDY: begin
				cmd.load_step = 1'b1;
				state_nx      = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.from_latch = 1'b1;
					row_active_nx  = 1'b1;
					state_nx       = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_active_q <= 1'b0;
		end else begin
			state_q      <= state_nx;
			row_active_q <= row_active_nx;
		end
	end

	// divider completes only while a division is awaited
	`FTRC_ASSERT_NOW(a_div_done_awaited, st.div_done,
		state_q == S_DDIS || state_q == S_WDX || state_q == S_WDY)
	// row set-up always starts with the distance division
	`FTRC_ASSERT_NEXT(a_load_to_dist, state_q == S_LOAD, state_q == S_DDIS)
	// the first pixel of a row leaves the row active
	`FTRC_ASSERT_NEXT(a_emit_activates, state_q == S_EMIT && cmd.emit,
		state_q == S_IDLE && row_active_q)

endmodule

/* hdl/floor_texture_row_caster.sv */
// top level of the floor texture row caster: controller plus datapath
// depends on ftrc_pkg, ftrc_ctrl, ftrc_datapath (and ftrc_div below it)
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  row, column
// result    out        out_valid/out_stall  floor_row, ceiling_row, pixel_column, texel_u, texel_v
// config    in         cfg_we               cfg_index, cfg_data
//
// a pixel of an active row is emitted straight from idle; column 0 below the horizon first
// sets up its row: a load state, the bit-serial distance division, then products, start
// points and steps per axis (steps by a shift and a reciprocal multiply)
// the result register takes a new result in the cycle the old one leaves
// reset is asynchronous and active low; there is no clearing pass
// input is stalled while a row is being set up or a result waits under out_stall
`timescale 1ns / 1ps

module floor_texture_row_caster (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ftrc_pkg::IDX_W-1:0] cfg_index,
	input  logic [ftrc_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ftrc_pkg::ROW_W-1:0] row,
	input  logic [ftrc_pkg::COL_W-1:0] column,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ftrc_pkg::ROW_W-1:0] floor_row,
	output logic [ftrc_pkg::ROW_W-1:0] ceiling_row,
	output logic [ftrc_pkg::COL_W-1:0] pixel_column,
	output logic [ftrc_pkg::TEX_W-1:0] texel_u,
	output logic [ftrc_pkg::TEX_W-1:0] texel_v
);
	import ftrc_pkg::*;

	cmd_t    cmd;
	status_t st;

	ftrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ftrc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.row          (row),
		.column       (column),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.floor_row    (floor_row),
		.ceiling_row  (ceiling_row),
		.pixel_column (pixel_column),
		.texel_u      (texel_u),
		.texel_v      (texel_v)
	);

endmodule
